>>> rtl/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg
// Shared sizes, codes and constants for the fixed-size block allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

    // Pool size and derived widths
    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int LINK_W     = IDX_W + 1;          // index plus null marker
    localparam int CNT_W      = 7;                  // block_count register
    localparam int SIZE_W     = 16;                 // block_size register
    localparam int OFFS_W     = 22;                 // byte offset result
    localparam int BUSY_W     = 7;                  // busy count result
    localparam int TOTAL_W    = 32;                 // alloc minus free, wrapping
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Null link marks an empty list
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);

    // Reset values of the configuration registers
    localparam logic [CNT_W-1:0]  BLOCK_COUNT_RST = CNT_W'(64);
    localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST  = SIZE_W'(24);

    // Operation codes
    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'b1;

endpackage

>>> rtl/fba_ram.sv
// ----------------------------------------------------------------------------
// fba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/fixed_block_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_allocator
// Pool allocator for equal-size blocks tracked by index, with a free list,
// a to-free list and a count of untouched blocks.
// ----------------------------------------------------------------------------
// Each word is taken when start is high and busy is low. busy then stays high
// through the execute cycle, and done pulses for one cycle right after,
// carrying status, result_index, byte_offset and busy_count; a new start
// may be given in that same done cycle, but no new word is taken while busy.
// The execute cycle is set by the link RAM: the head's next link is read
// in the accept cycle and arrives from the registered read port for the
// execute cycle that pops the head and writes back the lists.
// Results must be taken as they appear; there is no output stall. Config
// writes (cfg_write) belong in idle time only. The link RAM is not cleared
// after reset; lists only ever hold links written by a free.
// ----------------------------------------------------------------------------
module fixed_block_allocator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         op,
    input  logic [fba_pkg::IDX_W-1:0]          block_index,
    input  logic                               cfg_write,
    input  logic [fba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fba_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               done,
    output logic [1:0]                         status,
    output logic [fba_pkg::IDX_W-1:0]          result_index,
    output logic [fba_pkg::OFFS_W-1:0]         byte_offset,
    output logic [fba_pkg::BUSY_W-1:0]         busy_count
);

    import fba_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t               state_reg;
    op_t                  op_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [LINK_W-1:0]    free_head_reg,   free_head_next;
    logic [LINK_W-1:0]    tofree_head_reg, tofree_head_next;
    logic [CNT_W-1:0]     fresh_count_reg, fresh_count_next;
    logic [TOTAL_W-1:0]   diff_reg,        diff_next;
    logic [CNT_W-1:0]     block_count_reg;
    logic [SIZE_W-1:0]    block_size_reg;
    logic                 done_reg;
    status_t              status_reg,      status_next;
    logic [IDX_W-1:0]     result_index_reg, got;
    logic [OFFS_W-1:0]    byte_offset_reg;
    logic [BUSY_W-1:0]    busy_count_reg,  busy_count_next;

    logic                 accept;
    logic                 swap;
    logic [LINK_W-1:0]    head;
    logic [CNT_W-1:0]     eff_count;
    logic                 ram_we;
    logic [LINK_W-1:0]    ram_rdata;

    assign accept = start && (state_reg == S_IDLE);

    // Effective pool size, capped at the pool capacity
    assign eff_count = (block_count_reg > CNT_W'(MAX_BLOCKS)) ?
                       CNT_W'(MAX_BLOCKS) : block_count_reg;

    // Head used by an allocate: the to-free list takes over when all else is empty.
    // The lists do not change between accept and execute, so this serves both.
    assign swap = (free_head_reg == NULL_LINK) && (fresh_count_reg == '0) &&
                  (tofree_head_reg != NULL_LINK);
    assign head = swap ? tofree_head_reg : free_head_reg;

    // Link RAM: read the head's link at accept, write a link on a good free
    fba_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (tofree_head_reg),
        .raddr (head[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Execute step: list updates, counters and result
    always_comb
    begin
        free_head_next   = free_head_reg;
        tofree_head_next = tofree_head_reg;
        fresh_count_next = fresh_count_reg;
        diff_next        = diff_reg;
        status_next      = ST_OK;
        got              = '0;
        ram_we           = 1'b0;
        case (op_reg)
            OP_ALLOC:
            begin
                if (fresh_count_reg != '0)
                begin
                    fresh_count_next = fresh_count_reg - CNT_W'(1);
                    got              = fresh_count_next[IDX_W-1:0];
                    diff_next        = diff_reg + TOTAL_W'(1);
                end
                else if (head != NULL_LINK)
                begin
                    got            = head[IDX_W-1:0];
                    free_head_next = ram_rdata;
                    if (swap)
                    begin
                        tofree_head_next = NULL_LINK;
                    end
                    diff_next = diff_reg + TOTAL_W'(1);
                end
                else
                begin
                    status_next = ST_EMPTY;
                end
            end
            OP_FREE:
            begin
                if (CNT_W'(idx_reg) >= eff_count)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    ram_we           = (state_reg == S_EXEC);
                    tofree_head_next = LINK_W'(idx_reg);
                    diff_next        = diff_reg - TOTAL_W'(1);
                end
            end
            OP_INIT:
            begin
                if ((eff_count != '0) && (block_size_reg != '0))
                begin
                    free_head_next   = NULL_LINK;
                    tofree_head_next = NULL_LINK;
                    fresh_count_next = eff_count;
                    diff_next        = '0;
                end
            end
            default:
            begin
            end
        endcase

        // Busy count: signed difference clamped to 0..127
        if (diff_next[TOTAL_W-1])
        begin
            busy_count_next = '0;
        end
        else if (|diff_next[TOTAL_W-2:BUSY_W])
        begin
            busy_count_next = '1;
        end
        else
        begin
            busy_count_next = diff_next[BUSY_W-1:0];
        end
    end

    // Control, state and registered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            done_reg        <= 1'b0;
            free_head_reg   <= NULL_LINK;
            tofree_head_reg <= NULL_LINK;
            fresh_count_reg <= BLOCK_COUNT_RST;
            diff_reg        <= '0;
            block_count_reg <= BLOCK_COUNT_RST;
            block_size_reg  <= BLOCK_SIZE_RST;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg       <= S_IDLE;
                    done_reg        <= 1'b1;
                    free_head_reg   <= free_head_next;
                    tofree_head_reg <= tofree_head_next;
                    fresh_count_reg <= fresh_count_next;
                    diff_reg        <= diff_next;
                end
            endcase

            // Configuration writes
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_BLOCK_COUNT: block_count_reg <= cfg_data[CNT_W-1:0];
                    CFG_BLOCK_SIZE:  block_size_reg  <= cfg_data[SIZE_W-1:0];
                endcase
            end
        end
    end

    // Payload registers: input capture and result word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_t'(op);
            idx_reg <= block_index;
        end
        if (state_reg == S_EXEC)
        begin
            status_reg       <= status_next;
            result_index_reg <= got;
            byte_offset_reg  <= OFFS_W'(got * block_size_reg);
            busy_count_reg   <= busy_count_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign result_index = result_index_reg;
    assign byte_offset  = byte_offset_reg;
    assign busy_count   = busy_count_reg;

    // Checks
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_EXEC))
        else $error("done without an execute cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && !done)
        else $error("accepted word did not hold busy");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_EMPTY)) |-> (result_index == '0) && (byte_offset == '0))
        else $error("empty allocate returned a block");

    a_heads_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (free_head_reg <= NULL_LINK) && (tofree_head_reg <= NULL_LINK) &&
        (fresh_count_reg <= CNT_W'(MAX_BLOCKS)))
        else $error("list head or fresh count out of range");

endmodule
